### design/lpr_pkg.sv
// Shared constants and types for the LRU stack page replacement block.
package lpr_pkg;

  // Stack size and page number width.
  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;

  // Field widths; the depth and index widths are derived from the stack size.
  localparam int CFG_W   = 5;
  localparam int FAULT_W = 32;
  localparam int DEPTH_W = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  // Reset value of the frame count register.
  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);

  // One stack entry: a valid bit and a page number.
  typedef struct packed {
    logic                 valid;
    logic [PAGE_BITS-1:0] page;
  } entry_t;

  // Lookup outcome handed from the stack to the top level.
  typedef struct packed {
    logic                 hit;
    logic                 evict_valid;
    logic [PAGE_BITS-1:0] evict_page;
  } lookup_t;

endpackage

### design/lpr_cell.sv
// One LRU stack cell: holds one entry, compares it and takes its upper neighbor's entry.
module lpr_cell import lpr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 active_i,
  input  logic [PAGE_BITS-1:0] ref_page_i,
  input  logic                 found_i,
  input  entry_t               prev_i,
  output logic                 found_o,
  output entry_t               entry_o
);

  logic                 valid_q;
  logic [PAGE_BITS-1:0] page_q;
  logic                 match;
  logic                 load;

  // A cell matches when it is active, valid and holds the referenced page.
  assign match   = active_i & valid_q & (page_q == ref_page_i);
  assign found_o = found_i | match;

  // Cells at or above the matching place shift down; on a miss all active cells shift.
  assign load          = step_i & active_i & ~found_i;
  assign entry_o.valid = valid_q;
  assign entry_o.page  = page_q;

  // The valid bit is cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= prev_i.valid;
    end
  end

  // The page number needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      page_q <= prev_i.page;
    end
  end

endmodule

### design/lpr_stack.sv
// Chain of LRU cells with the hit search and the bottom-entry pick for eviction.
module lpr_stack import lpr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [DEPTH_W-1:0]   depth_i,
  input  logic [PAGE_BITS-1:0] ref_page_i,
  output lookup_t              lookup_o
);

  entry_t               ent [MAX_FRAMES];
  entry_t               top_entry;
  entry_t               bottom;
  logic [MAX_FRAMES:0]  found;
  logic [IDX_W-1:0]     bottom_idx;

  // The top cell takes the referenced page as its neighbor's entry.
  assign top_entry.valid = 1'b1;
  assign top_entry.page  = ref_page_i;
  assign found[0]        = 1'b0;

  // Row of identical cells; each sees its upper neighbor and the running match flag.
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    localparam logic [DEPTH_W-1:0] Pos = DEPTH_W'(i);
    entry_t prev;
    logic   active;

    assign active = (Pos < depth_i);
    if (i == 0) begin : g_top
      assign prev = top_entry;
    end else begin : g_rest
      assign prev = ent[i-1];
    end

    lpr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (step_i),
      .active_i   (active),
      .ref_page_i (ref_page_i),
      .found_i    (found[i]),
      .prev_i     (prev),
      .found_o    (found[i+1]),
      .entry_o    (ent[i])
    );
  end

  // The bottom active entry is the one that leaves on a miss.
  assign bottom_idx = IDX_W'(depth_i - DEPTH_W'(1));
  assign bottom     = ent[bottom_idx];

  assign lookup_o.hit         = found[MAX_FRAMES];
  assign lookup_o.evict_valid = ~found[MAX_FRAMES] & bottom.valid;
  assign lookup_o.evict_page  = (~found[MAX_FRAMES] & bottom.valid) ? bottom.page : '0;

endmodule

### design/lru_page_replacement.sv
// Top level of the LRU stack page replacement block.
//
//   Channel   Direction  Handshake                 Payload
//   -------   ---------  ------------------------  ------------------------------------
//   in        input      in_valid_i / in_ready_o   page_number_i
//   out       output     out_valid_o / out_ready_i hit_o, evicted_valid_o, evicted_page_o,
//                                                  fault_count_o
//   cfg       input      cfg_we_i (no wait)        cfg_wdata_i (frames in use)
//
// One request is taken per cycle unless a result is stalled; it appears in the output
// register on the next cycle; the combinational cell-row compare and shift sets this rate.
// Reset empties the stack, clears the fault count and sets the frame count to 16.
// While a result waits and out_ready_i is low, in_ready_o is low and nothing moves.
module lru_page_replacement import lpr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PAGE_BITS-1:0] page_number_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 hit_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic [FAULT_W-1:0]   fault_count_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  logic [CFG_W-1:0]   frames_q;
  logic [DEPTH_W-1:0] depth;
  logic [FAULT_W-1:0] fault_q;
  logic [FAULT_W-1:0] fault_d;
  logic               out_valid_q;
  logic               step;
  lookup_t            lookup;

  // Frame count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= FRAMES_RESET;
    end else if (cfg_we_i) begin
      frames_q <= cfg_wdata_i;
    end
  end

  // Clamp the frame count to one through the stack size.
  always_comb begin
    priority if (frames_q == '0) begin
      depth = DEPTH_W'(1);
    end else if (32'(frames_q) > 32'(MAX_FRAMES)) begin
      depth = DEPTH_W'(MAX_FRAMES);
    end else begin
      depth = DEPTH_W'(frames_q);
    end
  end

  // A request enters when the output register is free or being emptied.
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign step       = in_valid_i & in_ready_o;

  lpr_stack u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .depth_i    (depth),
    .ref_page_i (page_number_i),
    .lookup_o   (lookup)
  );

  // Saturating fault counter.
  assign fault_d = (!lookup.hit && fault_q != '1) ? fault_q + FAULT_W'(1) : fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        fault_q <= fault_d;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (step) begin
      hit_o           <= lookup.hit;
      evicted_valid_o <= lookup.evict_valid;
      evicted_page_o  <= lookup.evict_page;
      fault_count_o   <= fault_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### design/lpr_checker.sv
// Port-level checks for the LRU stack page replacement block, bound to the top level.
module lpr_port_checks import lpr_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic                 hit_o,
  input logic                 evicted_valid_o,
  input logic [PAGE_BITS-1:0] evicted_page_o,
  input logic [FAULT_W-1:0]   fault_count_o
);

  // A stalled result holds its fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) &&
      $stable(evicted_valid_o) && $stable(evicted_page_o) && $stable(fault_count_o))
    else $error("result changed while stalled");

  // A hit never evicts a page.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_valid_o)
    else $error("eviction reported on a hit");

  // Without an eviction the evicted page reads as zero.
  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_valid_o |-> evicted_page_o == '0)
    else $error("evicted page not zero without eviction");

  // A miss has always been counted.
  a_miss_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> fault_count_o != '0)
    else $error("miss reported with zero fault count");

  // With the output register empty a request is always taken.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request refused with an empty output register");

endmodule

bind lru_page_replacement lpr_port_checks u_lpr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .hit_o           (hit_o),
  .evicted_valid_o (evicted_valid_o),
  .evicted_page_o  (evicted_page_o),
  .fault_count_o   (fault_count_o)
);
